[hdl/kdef_pkg.sv]
// ----------------------------------------------------------------------------
// Key debounce event queue package
// Shared sizes, codes, types and helpers for the key debounce event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kdef_pkg;

  // Block sizing.
  localparam int unsigned NUM_KEYS   = 5;
  localparam int unsigned RING_SLOTS = 4;

  // Derived widths.
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CODE_W = $clog2(NUM_KEYS + 1);
  localparam int unsigned PTR_W  = $clog2(RING_SLOTS);

  // Counter saturation value and threshold reset value.
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;
  localparam logic [CNT_W-1:0] THR_RESET = 8'd3;

  // Input word commands.
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_GET  = 1'b1
  } cmd_t;

  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [NUM_KEYS-1:0] key_vec_t;

  // Operation strobes from the input stage to the datapath.
  typedef struct packed {
    logic tick;
    logic get;
  } op_ctl_t;

  // Ring pointer increment with wrap at the last slot.
  function automatic ptr_t ptr_wrap_inc(input ptr_t p);
    ptr_t res;
    if (p == PTR_W'(RING_SLOTS - 1)) begin
      res = '0;
    end else begin
      res = p + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/kdef_ifs.sv]
// ----------------------------------------------------------------------------
// Key debounce event queue channel interfaces
// Valid/ready channels for input words, result words and threshold writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: a sample tick with pin levels, or a request for an event.
interface kdef_in_if;
  import kdef_pkg::*;
  logic     valid;
  logic     ready;
  logic     cmd;
  key_vec_t pin_levels;
  modport source (output valid, output cmd, output pin_levels, input ready);
  modport sink   (input valid, input cmd, input pin_levels, output ready);
endinterface

// Result channel: one event code per request.
interface kdef_out_if;
  import kdef_pkg::*;
  logic  valid;
  logic  ready;
  code_t event_code;
  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

// Configuration channel: debounce threshold writes.
interface kdef_cfg_if;
  import kdef_pkg::*;
  logic valid;
  logic ready;
  cnt_t debounce_threshold;
  modport source (output valid, output debounce_threshold, input ready);
  modport sink   (input valid, input debounce_threshold, output ready);
endinterface

`default_nettype wire

[hdl/key_debounce_event_fifo_core.sv]
// ----------------------------------------------------------------------------
// Key debounce event queue, top level
// Debounces active-low keys and queues one event per debounced press.
// ----------------------------------------------------------------------------
// Usage:
// Words on in_bus are either a sample tick (cmd 0) carrying the raw pin levels,
// or a request (cmd 1) for the oldest queued event. A tick gives no word on
// out_bus; every request gives exactly one word, code 0 when the queue is
// empty and k+1 when key k was pressed. cfg_bus writes the debounce threshold
// and is always ready; write it only while the block is idle.
// Each input word goes into an input register. A tick is processed from there
// without waiting; a request is processed once the result register is free,
// and its result is loaded into the result register and shown on out_bus.
// One word is taken per cycle while no request waits in the input register;
// the key counters and ring pointers are updated as each word is processed.
// When out_bus stalls, the result register holds its word; ticks keep
// flowing, and a request waits in the input register until the result
// register frees up, which then also stalls in_bus.
// Reset clears the counters, fired flags, ring pointers and valid flags and
// sets the threshold to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_event_fifo_core (
  input  logic             clk,
  input  logic             rst_n,
  kdef_in_if.sink          in_bus,
  kdef_out_if.source       out_bus,
  kdef_cfg_if.sink         cfg_bus
);
  import kdef_pkg::*;

  cnt_t     thr_r;
  cnt_t     thr_nxt;
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  cmd_t     s1_cmd_r;
  key_vec_t s1_pins_r;
  logic     s1_adv;
  logic     out_valid_r;
  logic     out_valid_nxt;
  code_t    out_code_r;
  code_t    out_code_nxt;
  op_ctl_t  op;
  key_vec_t fire;
  code_t    pop_code;

  // Threshold register.
  assign cfg_bus.ready = 1'b1;
  assign thr_nxt       = cfg_bus.valid ? cfg_bus.debounce_threshold : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // Input stage: ticks always advance, requests wait for a free result slot.
  assign s1_adv = s1_valid_r &&
                  ((s1_cmd_r == CMD_TICK) || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = in_bus.ready ? in_bus.valid : s1_valid_r;

  assign op.tick = s1_adv && (s1_cmd_r == CMD_TICK);
  assign op.get  = s1_adv && (s1_cmd_r == CMD_GET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_cmd_r  <= cmd_t'(in_bus.cmd);
      s1_pins_r <= in_bus.pin_levels;
    end
  end

  // Per-key debounce.
  kdef_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .pin_levels (s1_pins_r),
    .threshold  (thr_r),
    .fire       (fire)
  );

  // Event queue.
  kdef_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .fire     (fire),
    .pop_code (pop_code)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (op.get) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = pop_code;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.event_code = out_code_r;

endmodule

`default_nettype wire

[hdl/kdef_debounce.sv]
// ----------------------------------------------------------------------------
// Key debounce counters
// Per-key saturating press counters and fired flags; flags new presses.
// ----------------------------------------------------------------------------
`default_nettype none

module kdef_debounce (
  input  logic              clk,
  input  logic              rst_n,
  input  kdef_pkg::op_ctl_t op,
  input  kdef_pkg::key_vec_t pin_levels,
  input  kdef_pkg::cnt_t    threshold,
  output kdef_pkg::key_vec_t fire
);
  import kdef_pkg::*;

  cnt_t     cnt_r   [NUM_KEYS];
  cnt_t     cnt_nxt [NUM_KEYS];
  cnt_t     cnt_inc [NUM_KEYS];
  key_vec_t fired_r;
  key_vec_t fired_nxt;

  // Each key is handled on its own; a fire sets the flag even if the push drops.
  always_comb begin
    fired_nxt = fired_r;
    fire      = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      cnt_inc[k] = (cnt_r[k] == CNT_MAX) ? cnt_r[k] : cnt_r[k] + CNT_W'(1);
      cnt_nxt[k] = cnt_r[k];
      if (op.tick) begin
        if (!pin_levels[k]) begin
          fire[k]      = (cnt_inc[k] >= threshold) && !fired_r[k];
          cnt_nxt[k]   = cnt_inc[k];
          fired_nxt[k] = fired_r[k] | fire[k];
        end else begin
          cnt_nxt[k]   = '0;
          fired_nxt[k] = 1'b0;
        end
      end
    end
  end

  // Counter and flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_r <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      fired_r <= fired_nxt;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/kdef_ring.sv]
// ----------------------------------------------------------------------------
// Key event ring queue
// Ring of event codes with one slot kept empty; pushes fired keys in order.
// ----------------------------------------------------------------------------
`default_nettype none

module kdef_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  kdef_pkg::op_ctl_t  op,
  input  kdef_pkg::key_vec_t fire,
  output kdef_pkg::code_t    pop_code
);
  import kdef_pkg::*;

  code_t ring_r   [RING_SLOTS];
  code_t ring_nxt [RING_SLOTS];
  ptr_t  head_r;
  ptr_t  head_nxt;
  ptr_t  tail_r;
  ptr_t  tail_nxt;

  // Pushes walk the keys in index order; a push that would fill the ring drops.
  always_comb begin
    ring_nxt = ring_r;
    tail_nxt = tail_r;
    head_nxt = head_r;
    pop_code = '0;
    if (op.tick) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (fire[k] && (ptr_wrap_inc(tail_nxt) != head_r)) begin
          ring_nxt[tail_nxt] = CODE_W'(k + 1);
          tail_nxt           = ptr_wrap_inc(tail_nxt);
        end
      end
    end
    if (op.get && (head_r != tail_r)) begin
      pop_code = ring_r[head_r];
      head_nxt = ptr_wrap_inc(head_r);
    end
  end

  // Ring storage holds payload only.
  always_ff @(posedge clk) begin
    ring_r <= ring_nxt;
  end

  // Pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/kdef_checker.sv]
// ----------------------------------------------------------------------------
// Key debounce event queue checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module kdef_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_cmd,
  input logic            out_valid,
  input logic            out_ready,
  input kdef_pkg::code_t out_event_code
);
  import kdef_pkg::*;

  // The result channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result follows an accepted request, through the input and result registers.
  a_result_from_get: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_cmd == CMD_GET), 2))
    else $error("result without a matching request");

  // Event codes name an existing key or mean no event.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_code <= CODE_W'(NUM_KEYS)))
    else $error("event code out of range");

  // A stalled result holds its code.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_code)))
    else $error("stalled result changed");

endmodule

bind key_debounce_event_fifo_core kdef_checker u_kdef_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_cmd         (in_bus.cmd),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_event_code (out_bus.event_code)
);

`default_nettype wire

[tb/tb_key_debounce_event_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debounce event queue testbench
// Sends tick and request words with random gaps on both channels and steps a
// model of the key counters, fired flags and event ring for every accepted
// word. Each returned event code is checked in order. The debounce threshold
// is swept between phases, from 0 and 1 up to 255.
// ----------------------------------------------------------------------------
module tb_key_debounce_event_fifo_core;
  import kdef_pkg::*;

  localparam int IDLE_PCT       = 25;
  localparam int STALL_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 10;

  // One input word as it is queued for the driver.
  typedef struct packed {
    cmd_t     cmd;
    key_vec_t pins;
  } key_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  kdef_in_if  in_bus ();
  kdef_out_if out_bus ();
  kdef_cfg_if cfg_bus ();

  key_debounce_event_fifo_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Model of the debounce state and the event ring.
  cnt_t        thr_model;
  cnt_t        press_cnt [NUM_KEYS];
  logic        fired [NUM_KEYS];
  code_t       ring [RING_SLOTS];
  int unsigned ring_head;
  int unsigned ring_tail;

  // Event codes still owed by the block, oldest first.
  code_t       expected_codes [$];
  key_word_t   pending_words [$];

  int words_queued;
  int words_taken;
  int cfg_writes;
  int fail_cnt;
  int ticks_sent;
  int gets_sent;
  int events_seen;
  int drops_seen;
  int idle_cycles;
  int hold_asks;
  int hold_served;
  int hold_left;
  bit in_taken;
  bit steady_run;

  function automatic void reset_model();
    int k;
    thr_model = THR_RESET;
    for (k = 0; k < NUM_KEYS; k++) begin
      press_cnt[k] = '0;
      fired[k]     = 1'b0;
    end
    for (k = 0; k < RING_SLOTS; k++) begin
      ring[k] = '0;
    end
    ring_head = 0;
    ring_tail = 0;
    expected_codes.delete();
  endfunction

  // Push a press event; the ring keeps one slot free, so a full ring drops it.
  function automatic void queue_event(input code_t code);
    int unsigned nxt;
    nxt = (ring_tail + 1) % RING_SLOTS;
    if (nxt == ring_head) begin
      drops_seen++;
    end else begin
      ring[ring_tail] = code;
      ring_tail       = nxt;
    end
  endfunction

  // Step the model by one accepted word.
  function automatic void debounce_word(input cmd_t cmd, input key_vec_t pins);
    int    k;
    code_t code;
    if (cmd == CMD_TICK) begin
      for (k = 0; k < NUM_KEYS; k++) begin
        if (!pins[k]) begin
          if (press_cnt[k] != CNT_MAX) begin
            press_cnt[k] = press_cnt[k] + 1'b1;
          end
          if (press_cnt[k] >= thr_model && !fired[k]) begin
            fired[k] = 1'b1;
            queue_event(code_t'(k + 1));
          end
        end else begin
          press_cnt[k] = '0;
          fired[k]     = 1'b0;
        end
      end
    end else begin
      code = '0;
      if (ring_head != ring_tail) begin
        code      = ring[ring_head];
        ring_head = (ring_head + 1) % RING_SLOTS;
      end
      expected_codes.push_back(code);
    end
  endfunction

  // Sample all three channels, step the model and check results.
  always @(posedge clk) begin : monitor
    code_t want;
    if (!rst_n) begin
      reset_model();
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_bus.valid && in_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) begin
        thr_model = cfg_bus.debounce_threshold;
        cfg_writes++;
      end
      if (in_bus.valid && in_bus.ready) begin
        debounce_word(cmd_t'(in_bus.cmd), in_bus.pin_levels);
        words_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_codes.size() == 0) begin
          $error("event_code: expected no word, got %0d", out_bus.event_code);
          fail_cnt++;
        end else begin
          want = expected_codes.pop_front();
          if (out_bus.event_code !== want) begin
            $error("event_code: expected %0d, got %0d", want, out_bus.event_code);
            fail_cnt++;
          end
          if (want != '0) begin
            events_seen++;
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no word moved for %0d cycles", idle_cycles);
        $display("FAIL key_debounce_event_fifo_core");
        $finish;
      end
    end
  end

  // Input driver: offers the next pending word, with random gaps.
  always @(negedge clk) begin : word_driver
    key_word_t w;
    if (rst_n && (!in_bus.valid || in_taken)) begin
      if (pending_words.size() != 0 &&
          (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
        w = pending_words.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.cmd        <= w.cmd;
        in_bus.pin_levels <= w.pins;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin : result_sink
    if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic add_word(input cmd_t cmd, input key_vec_t pins);
    key_word_t w;
    w.cmd  = cmd;
    w.pins = pins;
    pending_words.push_back(w);
    words_queued++;
    if (cmd == CMD_TICK) begin
      ticks_sent++;
    end else begin
      gets_sent++;
    end
  endtask

  // Block until every queued word is taken and every event code is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (words_taken != words_queued || expected_codes.size() != 0);
  endtask

  task automatic write_threshold(input cnt_t thr);
    int seen;
    wait_drained();
    // A tick may still be in the input register after the last result.
    repeat (SETTLE_CYCLES) @(negedge clk);
    seen = cfg_writes;
    cfg_bus.valid              <= 1'b1;
    cfg_bus.debounce_threshold <= thr;
    do @(negedge clk);
    while (cfg_writes == seen);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold a random set of keys around the threshold, with bounce and
  // interleaved requests, then release and read some events back.
  task automatic add_press_burst(input int thr, input int get_pct);
    int       mask;
    int       hold_len;
    int       bounce_pct;
    int       k;
    key_vec_t pins;
    mask       = $urandom_range(1, (1 << NUM_KEYS) - 1);
    bounce_pct = (thr >= 255) ? 0 : 8;
    if (thr >= 255) begin
      hold_len = $urandom_range(254, 258);
    end else begin
      hold_len = $urandom_range((thr > 1) ? thr - 1 : 1, thr + 3);
    end
    for (k = 0; k < hold_len; k++) begin
      pins = key_vec_t'(~mask);
      if ($urandom_range(0, 99) < bounce_pct) begin
        pins[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
      end
      add_word(CMD_TICK, pins);
      if ($urandom_range(0, 99) < get_pct) begin
        add_word(CMD_GET, key_vec_t'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      add_word(CMD_TICK, '1);
    end else begin
      add_word(CMD_TICK, key_vec_t'($urandom));
    end
    repeat ($urandom_range(0, 4)) add_word(CMD_GET, key_vec_t'($urandom));
  endtask

  // Mostly press bursts; the rest is random noise and plain event reads.
  task automatic add_random_words(input int thr, input int budget);
    int stop_at;
    int r;
    stop_at = words_queued + budget;
    while (words_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_press_burst(thr, 20);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) begin
          add_word(cmd_t'($urandom_range(0, 1)), key_vec_t'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 4)) add_word(CMD_GET, key_vec_t'($urandom));
      end
    end
  endtask

  // One threshold setting; the sender pauses halfway until all results are in.
  task automatic run_phase(input cnt_t thr, input int budget, input bit stall_rx,
                           input bit no_idle);
    write_threshold(thr);
    steady_run = no_idle;
    if (stall_rx) begin
      hold_asks++;
    end
    add_random_words(int'(thr), budget / 2);
    wait_drained();
    add_random_words(int'(thr), budget - budget / 2);
  endtask

  initial begin : stimulus
    int p;
    in_bus.valid               = 1'b0;
    in_bus.cmd                 = CMD_TICK;
    in_bus.pin_levels          = '1;
    out_bus.ready              = 1'b0;
    cfg_bus.valid              = 1'b0;
    cfg_bus.debounce_threshold = THR_RESET;
    steady_run                 = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset threshold: read from an empty ring, press all keys at once so the
    // ring fills and the last two pushes are dropped, then hold and release.
    add_word(CMD_GET, '1);
    add_word(CMD_TICK, '1);
    repeat (4) add_word(CMD_TICK, '0);
    repeat (4) add_word(CMD_GET, '1);
    add_word(CMD_TICK, '1);
    repeat (3) add_word(CMD_TICK, 5'h0A);
    repeat (3) add_word(CMD_GET, '0);
    add_word(CMD_TICK, 5'h15);

    // Threshold zero fires on the first pressed tick.
    write_threshold(8'd0);
    add_word(CMD_TICK, '1);
    add_word(CMD_TICK, 5'h0F);
    repeat (2) add_word(CMD_GET, '1);

    // Threshold one, which also fires on the first pressed tick.
    write_threshold(8'd1);
    add_word(CMD_TICK, 5'h1E);
    add_word(CMD_GET, '1);

    // Long receiver stall so the block backs up and stalls its input.
    run_phase(8'd2, 80, 1'b1, 1'b0);

    // Highest threshold: keys held for 254 to 258 ticks, around counter saturation.
    write_threshold(8'd255);
    add_press_burst(255, 1);
    repeat (3) add_word(CMD_GET, key_vec_t'($urandom));

    run_phase(8'd1, 70, 1'b0, 1'b0);
    run_phase(8'd4, 70, 1'b0, 1'b1);
    run_phase(8'd3, 70, 1'b0, 1'b0);
    for (p = 0; p < 4; p++) begin
      run_phase(cnt_t'($urandom_range(1, 8)), 70, 1'b0, 1'b0);
    end

    steady_run = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_codes.size() != 0) begin
      $error("event_code: %0d words never returned", expected_codes.size());
      fail_cnt++;
    end
    $display("Run covered %0d ticks and %0d event reads over %0d threshold writes (0 to 255).",
             ticks_sent, gets_sent, cfg_writes);
    $display("Key events returned: %0d; pushes dropped on a full ring: %0d.",
             events_seen, drops_seen);
    if (fail_cnt == 0) begin
      $display("PASS key_debounce_event_fifo_core");
    end else begin
      $display("FAIL key_debounce_event_fifo_core");
    end
    $finish;
  end

endmodule
